// ===== rtl/core/dtwf_pkg.sv =====
// Package for the double-tap wake filter: payload structs, event codes,
// job and state encodings, and reset constants. No dependencies.
`timescale 1ns / 1ps

package dtwf_pkg;

    // Default size of the active touch set.
    localparam int MAX_TOUCH_DEF = 16;

    // Register file of the configuration port.
    localparam int          CFG_IDX_W    = 8;
    localparam logic [15:0] INTERVAL_RST = 16'd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 8'd0,
        CFG_INTERVAL = 8'd1
    } t_cfg_reg;

    // Event codes on the cmd field.
    typedef enum logic [3:0] {
        CMD_MOTION      = 4'd0,
        CMD_BUTTON      = 4'd1,
        CMD_AXIS        = 4'd2,
        CMD_KEY         = 4'd3,
        CMD_TOUCH_DOWN  = 4'd4,
        CMD_TOUCH_UP    = 4'd5,
        CMD_TOUCH_MOVE  = 4'd6,
        CMD_TOOL_PROX   = 4'd7,
        CMD_TOOL_AXIS   = 4'd8,
        CMD_TOOL_TIP    = 4'd9,
        CMD_TOOL_BUTTON = 4'd10,
        CMD_PAD_BUTTON  = 4'd11,
        CMD_PAD_STRIP   = 4'd12,
        CMD_PAD_RING    = 4'd13,
        CMD_PAD_DIAL    = 4'd14,
        CMD_PROXIMITY   = 4'd15
    } t_cmd;

    // Key state codes.
    localparam logic [1:0] KEY_PRESSED  = 2'd0;
    localparam logic [1:0] KEY_RELEASED = 2'd1;

    // One input event.
    typedef struct packed {
        logic [3:0]  cmd;
        logic [7:0]  touch_id;
        logic [31:0] time_ms;
        logic        warp;
        logic        media_key;
        logic [1:0]  key_state;
        logic        pressed;
        logic        proximity_close;
        logic        sensor_valid;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic wake;
        logic consumed;
    } t_out_item;

    // Work that the back end carries out for one event.
    typedef enum logic [1:0] {
        OP_DIRECT = 2'd0,   // result fully decided by the front end
        OP_DOWN   = 2'd1,   // touch down through the tap detector
        OP_UP     = 2'd2,   // touch up through the tap detector
        OP_PROX   = 2'd3    // proximity sensor update
    } t_op;

    // Entry of the queue between front and back.
    typedef struct packed {
        t_op         op;
        logic [7:0]  touch_id;
        logic [31:0] time_ms;
        logic        prox_close;
        logic        wake;
        logic        consumed;
    } t_job;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_DOWN    = 3'd1,
        S_UP_SCAN = 3'd2,
        S_UP_LAST = 3'd3,
        S_UP_FIN  = 3'd4,
        S_EMIT    = 3'd5
    } t_state;

endpackage

// ===== rtl/core/dtwf_front.sv =====
// Front end of the double-tap wake filter: accepts input events and sorts
// them into jobs for the back end. Depends on dtwf_pkg.
`timescale 1ns / 1ps

module dtwf_front (
    input  logic             i_in_valid,
    input  dtwf_pkg::t_in_item i_in_item,
    output logic             o_in_stall,
    input  logic             i_enable,
    input  logic             i_q_full,
    output logic             o_push,
    output dtwf_pkg::t_job   o_job
);
    import dtwf_pkg::*;

    // The channel stalls only while the queue has no room.
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Classify the event and settle every result that needs no state.
    always_comb begin
        o_job.op         = OP_DIRECT;
        o_job.touch_id   = i_in_item.touch_id;
        o_job.time_ms    = i_in_item.time_ms;
        o_job.prox_close = i_in_item.proximity_close;
        o_job.wake       = 1'b0;
        o_job.consumed   = 1'b1;
        case (t_cmd'(i_in_item.cmd))
            CMD_MOTION: begin
                o_job.wake = !i_in_item.warp;
            end
            CMD_BUTTON, CMD_AXIS, CMD_PAD_STRIP, CMD_PAD_RING, CMD_PAD_DIAL: begin
                o_job.wake = 1'b1;
            end
            CMD_KEY: begin
                if (i_in_item.media_key) begin
                    o_job.consumed = 1'b0;
                end else if (i_in_item.key_state == KEY_PRESSED) begin
                    o_job.wake = 1'b1;
                end else if (i_in_item.key_state == KEY_RELEASED) begin
                    o_job.consumed = 1'b0;
                end
            end
            CMD_TOUCH_DOWN: begin
                if (i_enable) begin
                    o_job.op = OP_DOWN;
                end
            end
            CMD_TOUCH_UP: begin
                if (i_enable) begin
                    o_job.op = OP_UP;
                end
            end
            CMD_TOOL_TIP, CMD_TOOL_BUTTON, CMD_PAD_BUTTON: begin
                o_job.wake = i_in_item.pressed;
            end
            CMD_PROXIMITY: begin
                o_job.consumed = 1'b0;
                if (i_enable && i_in_item.sensor_valid) begin
                    o_job.op = OP_PROX;
                end
            end
            default: begin
                o_job.consumed = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/core/dtwf_queue.sv =====
// Two-entry job queue between the front and back ends of the filter.
// Depends on dtwf_pkg.
`timescale 1ns / 1ps

module dtwf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dtwf_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dtwf_pkg::t_job o_job
);
    import dtwf_pkg::*;

    t_job       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_entry[r_rd_ptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/core/dtwf_back.sv =====
// Back end of the double-tap wake filter: touch set, tap timer, proximity
// flag and the result register. Depends on dtwf_pkg.
`timescale 1ns / 1ps

module dtwf_back #(
    parameter int MAX_TOUCH = dtwf_pkg::MAX_TOUCH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  dtwf_pkg::t_job      i_job,
    output logic                o_pop,
    input  logic [15:0]         i_interval,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dtwf_pkg::t_out_item o_out_item
);
    import dtwf_pkg::*;

    localparam int IDX_W = (MAX_TOUCH > 1) ? $clog2(MAX_TOUCH) : 1;
    localparam int CNT_W = $clog2(MAX_TOUCH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TOUCH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TOUCH);

    t_state            r_state;
    t_state            n_state;
    t_job              r_job;
    t_out_item         r_res;
    t_out_item         r_out_item;
    logic              r_out_vld;
    logic [MAX_TOUCH-1:0] r_used;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_chk_idx;
    logic              r_chk_vld;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_mem [MAX_TOUCH];
    logic              r_running;
    logic [31:0]       r_start;
    logic              r_second;
    logic              r_near;

    logic              out_free;
    logic              load_out;
    logic              down_hit;
    logic              scan_issue;
    logic              chk_hit;
    logic              set_empty;
    logic              set_full;
    logic [31:0]       job_elapsed;
    logic [31:0]       held_elapsed;
    logic              job_quick;
    logic              held_quick;

    assign set_empty    = (r_count == '0);
    assign set_full     = (r_count == FULL_CNT);
    assign out_free     = !r_out_vld || !i_out_stall;
    assign job_elapsed  = i_job.time_ms - r_start;
    assign held_elapsed = r_job.time_ms - r_start;
    assign job_quick    = job_elapsed < {16'd0, i_interval};
    assign held_quick   = held_elapsed < {16'd0, i_interval};
    assign chk_hit      = r_chk_vld && r_used[r_chk_idx] && (r_rd_data == r_job.touch_id);

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    case (i_job.op)
                        OP_DOWN:  n_state = set_full ? S_EMIT : S_DOWN;
                        OP_UP:    n_state = S_UP_SCAN;
                        default:  n_state = S_EMIT;
                    endcase
                end
            end
            S_DOWN: begin
                if (!r_used[r_idx]) begin
                    n_state = S_EMIT;
                end
            end
            S_UP_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_UP_LAST;
                end
            end
            S_UP_LAST: n_state = S_UP_FIN;
            S_UP_FIN:  n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_pop      = 1'b0;
        load_out   = 1'b0;
        down_hit   = 1'b0;
        scan_issue = 1'b0;
        case (r_state)
            S_IDLE:    o_pop      = !i_q_empty;
            S_DOWN:    down_hit   = !r_used[r_idx];
            S_UP_SCAN: scan_issue = 1'b1;
            S_EMIT:    load_out   = out_free;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Control state, touch set bookkeeping and tap detector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_running <= 1'b0;
            r_start   <= '0;
            r_second  <= 1'b0;
            r_near    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            // Take a job and apply the timer update of a touch down or the near flag of a proximity job.
            if (o_pop) begin
                r_idx <= '0;
                if (i_job.op == OP_DOWN) begin
                    if (set_empty) begin
                        if (!r_running) begin
                            r_running <= 1'b1;
                            r_start   <= i_job.time_ms;
                        end else if (job_quick) begin
                            r_second <= 1'b1;
                        end else begin
                            r_start <= i_job.time_ms;
                        end
                    end else begin
                        r_running <= 1'b0;
                        r_second  <= 1'b0;
                    end
                end
                if (i_job.op == OP_PROX) begin
                    r_near <= i_job.prox_close;
                end
            end

            // Touch down: look for the first free slot.
            if (r_state == S_DOWN) begin
                if (down_hit) begin
                    r_used[r_idx] <= 1'b1;
                    r_count       <= r_count + CNT_W'(1);
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end

            // Touch up: read one slot a cycle, compare the registered read in the next cycle.
            if (scan_issue) begin
                r_chk_vld <= 1'b1;
                r_chk_idx <= r_idx;
                if (r_idx != LAST_IDX) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end else begin
                r_chk_vld <= 1'b0;
            end
            if (chk_hit) begin
                r_used[r_chk_idx] <= 1'b0;
                r_count           <= r_count - CNT_W'(1);
            end

            // Touch up: the set is settled, judge the double tap.
            if (r_state == S_UP_FIN && set_empty && r_running && r_second) begin
                r_running <= 1'b0;
                r_second  <= 1'b0;
            end

            // Result register.
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Held job, its result and the output payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job          <= i_job;
            r_res.wake     <= i_job.wake;
            r_res.consumed <= i_job.consumed;
        end
        if (r_state == S_UP_FIN && set_empty && r_running && r_second) begin
            r_res.wake <= held_quick && !r_near;
        end
        if (load_out) begin
            r_out_item <= r_res;
        end
    end

    // Slot id memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (down_hit) begin
            r_mem[r_idx] <= r_job.touch_id;
        end
        r_rd_data <= r_mem[r_idx];
    end

endmodule

// ===== rtl/core/double_tap_wake_filter.sv =====
// Top level of the double-tap wake filter: configuration registers, front
// end, job queue and back end. Depends on dtwf_pkg and the dtwf modules.
//
// Usage: input events arrive on i_in_valid / o_in_stall with an i_in_item
// payload; one result per event leaves on o_out_valid / i_out_stall as
// o_out_item, in event order. Registers are written on i_cfg_valid with
// o_cfg_ready, which is always high; index 0 is the double-tap enable,
// index 1 the tap interval in ms; other indexes are ignored.
// An event with no touch-set work goes from the queue straight to the
// result register. A touch down first searches the touch set for a free
// slot unless the set is full; a touch up checks every slot, with the
// slot id memory being read one slot per cycle. The back end finishes one
// event before it takes the next; a two-entry queue keeps taking events
// while the back end works. When the receiver stalls, the result is held
// in the output register, the queue fills, and then o_in_stall rises.
// Reset empties the queue and the touch set, stops the tap timer, clears
// the near flag, enables detection and sets the interval to 400 ms.
`timescale 1ns / 1ps

module double_tap_wake_filter #(
    parameter int MAX_TOUCH = dtwf_pkg::MAX_TOUCH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  dtwf_pkg::t_in_item                    i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output dtwf_pkg::t_out_item                   o_out_item,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [dtwf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [15:0]                           i_cfg_data
);
    import dtwf_pkg::*;

    logic        r_enable;
    logic [15:0] r_interval;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_job        front_job;
    t_job        head_job;

    // Configuration registers; a transfer is taken in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b1;
            r_interval <= INTERVAL_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                CFG_INTERVAL: r_interval <= i_cfg_data;
                default:      r_enable   <= r_enable;
            endcase
        end
    end

    // Front end sorts events into jobs.
    dtwf_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_enable   (r_enable),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (front_job)
    );

    // Queue decouples the two sides.
    dtwf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    // Back end runs the tap detector and holds the result.
    dtwf_back #(
        .MAX_TOUCH (MAX_TOUCH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .i_interval  (r_interval),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/tb_double_tap_wake_filter.sv =====
// Self-checking testbench for double_tap_wake_filter: directed and random events
// are checked against an in-bench model of the wake and tap logic.
// Depends on dtwf_pkg and the double_tap_wake_filter RTL.
`timescale 1ns / 1ps

module tb_double_tap_wake_filter;
    import dtwf_pkg::*;

    localparam int TOUCH_SLOTS = MAX_TOUCH_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_SETTLE = TOUCH_SLOTS + 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'hFF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_item;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // Model of the configuration and detector state.
    logic dt_enable;
    logic [15:0] tap_interval;
    logic slot_used [TOUCH_SLOTS];
    logic [7:0] slot_id [TOUCH_SLOTS];
    logic tap_running;
    logic [31:0] tap_start;
    logic second_tap;
    logic obj_near;

    t_out_item wake_expect_q[$];
    t_out_item want;
    int err_count = 0;
    int items_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    logic [31:0] now_ms = 32'd5000;

    // Receiver stall pattern state.
    int stall_mode = 0;
    int stall_hold = 0;
    logic [3:0] stall_phase = '0;

    always #1 i_clk = ~i_clk;

    double_tap_wake_filter #(
        .MAX_TOUCH(TOUCH_SLOTS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    function automatic logic touch_set_empty();
        for (int i = 0; i < TOUCH_SLOTS; i++) begin
            if (slot_used[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Elapsed time wraps modulo 2^32; quick means strictly under the interval.
    function automatic logic tap_is_quick(input logic [31:0] now);
        logic [31:0] elapsed;
        elapsed = now - tap_start;
        return elapsed < {16'd0, tap_interval};
    endfunction

    function automatic void touch_down(input logic [7:0] id, input logic [31:0] now);
        logic placed;
        placed = 1'b0;
        if (touch_set_empty()) begin
            if (!tap_running) begin
                tap_running = 1'b1;
                tap_start = now;
            end else if (tap_is_quick(now)) begin
                second_tap = 1'b1;
            end else begin
                tap_start = now;
            end
        end else begin
            tap_running = 1'b0;
            second_tap = 1'b0;
        end
        // A full set drops the id; duplicates take a slot of their own.
        for (int i = 0; i < TOUCH_SLOTS; i++) begin
            if (!placed && !slot_used[i]) begin
                slot_used[i] = 1'b1;
                slot_id[i] = id;
                placed = 1'b1;
            end
        end
    endfunction

    function automatic logic touch_up(input logic [7:0] id, input logic [31:0] now);
        logic woke;
        woke = 1'b0;
        for (int i = 0; i < TOUCH_SLOTS; i++) begin
            if (slot_used[i] && slot_id[i] == id) slot_used[i] = 1'b0;
        end
        if (touch_set_empty() && tap_running && second_tap) begin
            woke = tap_is_quick(now) && !obj_near;
            tap_running = 1'b0;
            second_tap = 1'b0;
        end
        return woke;
    endfunction

    // Works out the result of one event and advances the model state.
    function automatic t_out_item predict_wake(input t_in_item ev);
        t_out_item res;
        res.wake = 1'b0;
        res.consumed = 1'b1;
        case (ev.cmd)
            CMD_MOTION: res.wake = !ev.warp;
            CMD_BUTTON, CMD_AXIS, CMD_PAD_STRIP, CMD_PAD_RING, CMD_PAD_DIAL: begin
                res.wake = 1'b1;
            end
            CMD_KEY: begin
                if (ev.media_key) res.consumed = 1'b0;
                else if (ev.key_state == KEY_PRESSED) res.wake = 1'b1;
                else if (ev.key_state == KEY_RELEASED) res.consumed = 1'b0;
            end
            CMD_TOUCH_DOWN: begin
                if (dt_enable) touch_down(ev.touch_id, ev.time_ms);
            end
            CMD_TOUCH_UP: begin
                if (dt_enable) res.wake = touch_up(ev.touch_id, ev.time_ms);
            end
            CMD_TOOL_TIP, CMD_TOOL_BUTTON, CMD_PAD_BUTTON: res.wake = ev.pressed;
            CMD_PROXIMITY: begin
                res.consumed = 1'b0;
                if (dt_enable && ev.sensor_valid) obj_near = ev.proximity_close;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_in_item mk_event(input t_cmd c, input logic [7:0] id,
                                          input logic [31:0] t);
        t_in_item ev;
        ev = '0;
        ev.cmd = c;
        ev.touch_id = id;
        ev.time_ms = t;
        return ev;
    endfunction

    // Sends one event in bursts with random gaps; valid stays high across a burst.
    task automatic send_event(input t_in_item ev);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
        i_in_valid <= 1'b1;
        i_in_item <= ev;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        wake_expect_q.push_back(predict_wake(ev));
        items_sent++;
        burst_left--;
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (wake_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ENABLE: dt_enable = data[0];
            CFG_INTERVAL: tap_interval = data;
            default: ;
        endcase
    endtask

    // Only called with the block idle; the unused index must be ignored.
    task automatic set_config(input logic [15:0] enable_word, input logic [15:0] interval);
        write_reg(CFG_ENABLE, enable_word);
        write_reg(CFG_INTERVAL, interval);
        write_reg(CFG_UNUSED_IDX, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // While detection is enabled, lifts every finger still down so that the next tap starts from an empty set.
    task automatic clear_touches();
        logic found;
        logic [7:0] id;
        found = 1'b1;
        while (dt_enable && found) begin
            found = 1'b0;
            for (int i = 0; i < TOUCH_SLOTS; i++) begin
                if (!found && slot_used[i]) begin
                    found = 1'b1;
                    id = slot_id[i];
                end
            end
            if (found) begin
                send_event(mk_event(CMD_TOUCH_UP, id, now_ms));
                now_ms += $urandom_range(1, 30);
            end
        end
    endtask

    // Time offsets clustered around the interval edge.
    function automatic logic [31:0] pick_gap();
        case ($urandom_range(0, 5))
            0: return {16'd0, tap_interval} - 32'd1;
            1: return {16'd0, tap_interval};
            2: return {16'd0, tap_interval} + 32'd1;
            3: return $urandom_range(0, tap_interval);
            4: return $urandom_range(0, 2 * tap_interval + 2);
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    task automatic send_proximity();
        t_in_item ev;
        ev = mk_event(CMD_PROXIMITY, 8'($urandom), now_ms);
        ev.sensor_valid = ($urandom_range(0, 3) != 0);
        ev.proximity_close = 1'($urandom_range(0, 1));
        send_event(ev);
    endtask

    // One tap-tap gesture with random timing, sometimes disturbed.
    task automatic run_tap_pair();
        logic [7:0] id;
        logic [7:0] up_id;
        logic [31:0] t0;
        logic [31:0] second_at;
        logic [31:0] second_end;
        logic [31:0] first_end;
        clear_touches();
        if ($urandom_range(0, 5) == 0) send_proximity();
        id = 8'($urandom_range(0, 255));
        t0 = now_ms;
        second_at = pick_gap();
        second_end = second_at + (($urandom_range(0, 3) == 0) ? pick_gap()
                                                              : $urandom_range(0, 40));
        first_end = $urandom_range(0, second_at);
        up_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : id;
        send_event(mk_event(CMD_TOUCH_DOWN, id, t0));
        if ($urandom_range(0, 9) == 0) begin
            send_event(mk_event(CMD_TOUCH_DOWN, 8'($urandom), t0 + first_end));
        end
        send_event(mk_event(CMD_TOUCH_UP, up_id, t0 + first_end));
        if ($urandom_range(0, 7) == 0) send_proximity();
        id = ($urandom_range(0, 1) == 0) ? id : 8'($urandom);
        send_event(mk_event(CMD_TOUCH_DOWN, id, t0 + second_at));
        send_event(mk_event(CMD_TOUCH_UP, id, t0 + second_end));
        now_ms = t0 + second_end + $urandom_range(0, 3000);
    endtask

    // Many fingers from a small id pool: can fill the set and makes duplicates.
    task automatic run_crowd();
        logic [7:0] pool [4];
        int fingers;
        foreach (pool[k]) pool[k] = 8'($urandom_range(0, 255));
        fingers = $urandom_range(2, TOUCH_SLOTS + 4);
        for (int n = 0; n < fingers; n++) begin
            send_event(mk_event(CMD_TOUCH_DOWN, pool[$urandom_range(0, 3)], now_ms));
            now_ms += $urandom_range(0, 50);
        end
        foreach (pool[k]) begin
            send_event(mk_event(CMD_TOUCH_UP, pool[k], now_ms));
            now_ms += $urandom_range(0, 50);
        end
    endtask

    task automatic run_random_mix(input int count);
        int target;
        int pick;
        logic [63:0] raw;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                run_tap_pair();
            end else if (pick < 58) begin
                run_crowd();
            end else if (pick < 68) begin
                send_proximity();
            end else begin
                raw = {$urandom, $urandom};
                send_event(t_in_item'(raw[$bits(t_in_item)-1:0]));
            end
            // Occasional jumps let the clock stamp wrap and cover every bit.
            if ($urandom_range(0, 19) == 0) now_ms = $urandom;
            else if ($urandom_range(0, 29) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
        end
    endtask

    // Every event code but touch down and touch up, with its flag extremes.
    task automatic test_event_codes();
        t_in_item ev;
        ev = mk_event(CMD_MOTION, 8'h00, 32'h0000_0000);
        send_event(ev);
        ev.warp = 1'b1;
        ev.touch_id = 8'hFF;
        ev.time_ms = 32'hFFFF_FFFF;
        send_event(ev);
        send_event(mk_event(CMD_BUTTON, 8'h5A, 32'h1234_5678));
        send_event(mk_event(CMD_AXIS, 8'hA5, 32'h8765_4321));
        ev = mk_event(CMD_KEY, 8'h00, 32'd10);
        ev.media_key = 1'b1;
        send_event(ev);
        ev.media_key = 1'b0;
        for (int ks = 0; ks < 4; ks++) begin
            ev.key_state = 2'(ks);
            send_event(ev);
        end
        send_event(mk_event(CMD_TOUCH_MOVE, 8'h11, 32'd20));
        send_event(mk_event(CMD_TOOL_PROX, 8'h22, 32'd30));
        send_event(mk_event(CMD_TOOL_AXIS, 8'h33, 32'd40));
        ev = mk_event(CMD_TOOL_TIP, 8'h44, 32'd50);
        send_event(ev);
        ev.pressed = 1'b1;
        send_event(ev);
        ev.cmd = CMD_TOOL_BUTTON;
        send_event(ev);
        ev.cmd = CMD_PAD_BUTTON;
        send_event(ev);
        send_event(mk_event(CMD_PAD_STRIP, 8'h55, 32'd60));
        send_event(mk_event(CMD_PAD_RING, 8'h66, 32'd70));
        send_event(mk_event(CMD_PAD_DIAL, 8'h77, 32'd80));
        // A reading from a missing sensor must not set the near flag.
        ev = mk_event(CMD_PROXIMITY, 8'h88, 32'd90);
        ev.proximity_close = 1'b1;
        send_event(ev);
    endtask

    // Quick double tap across the wrap of the clock stamp: wakes at default interval.
    task automatic test_double_tap_wrap();
        send_event(mk_event(CMD_TOUCH_DOWN, 8'h00, 32'hFFFF_FF00));
        send_event(mk_event(CMD_TOUCH_UP, 8'h00, 32'hFFFF_FF40));
        send_event(mk_event(CMD_TOUCH_DOWN, 8'hFF, 32'h0000_0010));
        send_event(mk_event(CMD_TOUCH_UP, 8'hFF, 32'h0000_0020));
    endtask

    // A near object blocks an otherwise valid double tap.
    task automatic test_near_object();
        t_in_item ev;
        ev = mk_event(CMD_PROXIMITY, 8'h00, 32'd1000);
        ev.sensor_valid = 1'b1;
        ev.proximity_close = 1'b1;
        send_event(ev);
        send_event(mk_event(CMD_TOUCH_DOWN, 8'h07, 32'd2000));
        send_event(mk_event(CMD_TOUCH_UP, 8'h07, 32'd2010));
        send_event(mk_event(CMD_TOUCH_DOWN, 8'h07, 32'd2100));
        send_event(mk_event(CMD_TOUCH_UP, 8'h07, 32'd2110));
    endtask

    // Random traffic under several register settings, extremes included.
    task automatic test_config_sweep();
        run_random_mix(95);
        drain_results();
        set_config(16'hFFFE, 16'($urandom));
        run_random_mix(90);
        drain_results();
        set_config(16'h0001, 16'h0000);
        run_random_mix(90);
        drain_results();
        set_config(16'hFFFF, 16'hFFFF);
        run_random_mix(90);
        drain_results();
        set_config(16'h0001, 16'h0001);
        run_random_mix(90);
        drain_results();
        set_config(16'h0001, 16'($urandom_range(50, 1000)));
        run_random_mix(90);
        drain_results();
        set_config(16'h0001, INTERVAL_RST);
        run_random_mix(30);
    endtask

    // Receiver stalls follow a random mode that is redrawn when its hold count runs out.
    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_hold <= $urandom_range(20, 150);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        stall_phase <= stall_phase + 4'd1;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= stall_phase[2];
        endcase
    end

    // Each result transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (wake_expect_q.size() == 0) begin
                $error("result with nothing expected: wake %0b consumed %0b",
                       o_out_item.wake, o_out_item.consumed);
                err_count++;
            end else begin
                want = wake_expect_q.pop_front();
                if (o_out_item.wake !== want.wake) begin
                    $error("wake: expected %0b, got %0b", want.wake, o_out_item.wake);
                    err_count++;
                end
                if (o_out_item.consumed !== want.consumed) begin
                    $error("consumed: expected %0b, got %0b", want.consumed,
                           o_out_item.consumed);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_double_tap_wake_filter: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        dt_enable = 1'b1;
        tap_interval = INTERVAL_RST;
        foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_id[i] = 8'h00;
        end
        tap_running = 1'b0;
        tap_start = '0;
        second_tap = 1'b0;
        obj_near = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_event_codes();
        test_double_tap_wrap();
        test_near_object();
        drain_results();
        set_config(16'h0001, INTERVAL_RST);
        test_config_sweep();

        drain_results();
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_double_tap_wake_filter: done, clean");
        end else begin
            $display("tb_double_tap_wake_filter: done, errors");
        end
        $finish;
    end

endmodule

// ===== double_tap_wake_filter.f =====
rtl/core/dtwf_pkg.sv
rtl/core/dtwf_front.sv
rtl/core/dtwf_queue.sv
rtl/core/dtwf_back.sv
rtl/core/double_tap_wake_filter.sv
tb/tb_double_tap_wake_filter.sv
